@@ hdl/bcdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdt_pkg
// Shared types and constants of the binary CNF to DIMACS text formatter.
// ----------------------------------------------------------------------------
package bcdt_pkg;

   localparam logic [31:0] CNF_MAGIC = 32'h4641_5049;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned COUNT_W = 64;
   localparam int unsigned DIGIT_MAX = 20;

   // Result status codes.
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_MAGIC = 2'd2;
   localparam logic [1:0] ST_TRUNC = 2'd3;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;

   // Datapath operations requested by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD_VARS,
      OP_LOAD_CLAUSES,
      OP_LOAD_LIT,
      OP_DIV_STEP
   } op_type;

   typedef struct packed {
      op_type op;
      logic [WORD_W-1:0] word;
   } dp_cmd_type;

   typedef struct packed {
      logic digit_done;
      logic [4:0] digit_cnt;
      logic [7:0] digit_char;
      logic lit_neg;
      logic lit_zero;
   } dp_sts_type;

   // Constant text, "p cnf " and "solve\n".
   function automatic logic [7:0] pcnf_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h70;
         3'd1: c = 8'h20;
         3'd2: c = 8'h63;
         3'd3: c = 8'h6E;
         3'd4: c = 8'h66;
         default: c = 8'h20;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] solve_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h73;
         3'd1: c = 8'h6F;
         3'd2: c = 8'h6C;
         3'd3: c = 8'h76;
         3'd4: c = 8'h65;
         default: c = 8'h0A;
      endcase
      return c;
   endfunction

endpackage

@@ hdl/bcdt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdt_datapath
// Decimal conversion: long division by ten, one 16-bit limb per cycle,
// four limbs per digit. Digits are kept in a stack.
// ----------------------------------------------------------------------------
module bcdt_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bcdt_pkg::dp_cmd_type  cmd,
   input  logic                  pop,
   input  logic [63:0]           vars_val,
   input  logic [63:0]           clauses_val,
   output bcdt_pkg::dp_sts_type  sts
);

   logic [63:0] value_ff, value_in;
   logic [3:0] digit_ff [bcdt_pkg::DIGIT_MAX];
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] limb_ff, limb_in;
   logic [3:0] carry_ff, carry_in;
   logic neg_ff, neg_in;
   logic zero_ff, zero_in;
   logic [19:0] part;
   logic [39:0] prod;
   logic [15:0] part_q;
   logic [19:0] back;
   logic [3:0] part_r;

   // One limb of the long division. The partial dividend is the carried
   // remainder above the limb, so it stays below 655360, where the
   // reciprocal multiply by 0xCCCCD with a shift of 23 is exact.
   always_comb begin
      part = {carry_ff, value_ff[{limb_ff, 4'd0} +: 16]};
      prod = part * 20'hCCCCD;
      part_q = prod[38:23];
      back = 20'({part_q, 3'd0}) + 20'({part_q, 1'b0});
      part_r = 4'(part - back);
   end

   always_comb begin
      value_in = value_ff;
      cnt_in = cnt_ff;
      limb_in = limb_ff;
      carry_in = carry_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      unique case (cmd.op)
         bcdt_pkg::OP_LOAD_VARS: begin
            value_in = vars_val;
            cnt_in = '0;
            limb_in = 2'd3;
            carry_in = '0;
         end
         bcdt_pkg::OP_LOAD_CLAUSES: begin
            value_in = clauses_val;
            cnt_in = '0;
            limb_in = 2'd3;
            carry_in = '0;
         end
         bcdt_pkg::OP_LOAD_LIT: begin
            neg_in = cmd.word[31];
            zero_in = (cmd.word == '0);
            value_in = {32'd0, cmd.word[31] ? (~cmd.word + 32'd1) : cmd.word};
            cnt_in = '0;
            limb_in = 2'd3;
            carry_in = '0;
         end
         bcdt_pkg::OP_DIV_STEP: begin
            value_in[{limb_ff, 4'd0} +: 16] = part_q;
            limb_in = limb_ff - 2'd1;
            if (limb_ff == 2'd0) begin
               carry_in = '0;
               cnt_in = cnt_ff + 5'd1;
            end else begin
               carry_in = part_r;
            end
         end
         default: ;
      endcase
      if (pop) cnt_in = cnt_ff - 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         limb_ff <= 2'd3;
         carry_ff <= '0;
         neg_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         limb_ff <= limb_in;
         carry_ff <= carry_in;
         neg_ff <= neg_in;
         zero_ff <= zero_in;
      end
      value_ff <= value_in;
      if (cmd.op == bcdt_pkg::OP_DIV_STEP && limb_ff == 2'd0)
         digit_ff[cnt_ff] <= part_r;
   end

   logic [4:0] top_idx;
   assign top_idx = cnt_ff - 5'd1;
   // The value only counts as used up between digits.
   assign sts.digit_done = (value_ff == '0) && (limb_ff == 2'd3);
   assign sts.digit_cnt = cnt_ff;
   assign sts.digit_char = bcdt_pkg::CH_ZERO | {4'd0, digit_ff[top_idx]};
   assign sts.lit_neg = neg_ff;
   assign sts.lit_zero = zero_ff;

endmodule

@@ hdl/bcdt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdt_ctrl
// Sequencer: header parsing, text sequencing and result register.
// ----------------------------------------------------------------------------
module bcdt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  solve_mode,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [31:0]           in_word,
   input  logic                  in_end,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_byte,
   output logic [1:0]            out_status,
   output logic                  out_last,
   output logic                  out_done,
   output bcdt_pkg::dp_cmd_type  cmd,
   output logic                  pop,
   output logic [63:0]           vars_val,
   output logic [63:0]           clauses_val,
   input  bcdt_pkg::dp_sts_type  sts
);

   typedef enum logic [3:0] {
      S_IDLE, S_PCNF, S_VDIV, S_VOUT, S_SP1, S_CDIV, S_COUT, S_NL1,
      S_LMINUS, S_LDIV, S_LOUT, S_LSP, S_LNL, S_SOLVE, S_ERR, S_DEAD
   } state_type;

   state_type state_ff;
   logic [2:0] hidx_ff, tidx_ff;
   logic [63:0] ctot_ff, vtot_ff, cdone_ff;
   logic magic_ff, end_ff, fin_ff;
   logic [1:0] err_ff;
   logic ov_ff, ov_in;
   logic [7:0] ob_ff;
   logic [1:0] os_ff;
   logic ol_ff, od_ff;

   logic can_emit;
   logic emit_now;
   logic conv_done;
   logic hdr_last;
   logic [63:0] cdone_inc;
   assign can_emit = !ov_ff || out_ready;
   // Once the job has ended, words are still taken but dropped.
   assign in_ready = (state_ff == S_IDLE) || fin_ff;
   assign hdr_last = (hidx_ff == 3'd6);
   assign cdone_inc = cdone_ff + 64'd1;
   assign conv_done = sts.digit_done && (sts.digit_cnt != '0);

   assign out_valid = ov_ff;
   assign out_byte = ob_ff;
   assign out_status = os_ff;
   assign out_last = ol_ff;
   assign out_done = od_ff;
   assign vars_val = vtot_ff;
   assign clauses_val = ctot_ff;

   always_comb begin
      unique case (state_ff)
         S_PCNF, S_VOUT, S_SP1, S_COUT, S_NL1, S_LMINUS, S_LOUT, S_LSP, S_LNL,
         S_SOLVE, S_ERR: emit_now = can_emit;
         default: emit_now = 1'b0;
      endcase
   end

   assign ov_in = emit_now || (ov_ff && !out_ready);

   always_comb begin
      cmd.op = bcdt_pkg::OP_NONE;
      cmd.word = in_word;
      pop = 1'b0;
      unique case (state_ff)
         S_IDLE: if (in_valid && in_ready && hidx_ff == 3'd7)
            cmd.op = bcdt_pkg::OP_LOAD_LIT;
         S_PCNF: if (can_emit && tidx_ff == 3'd5) cmd.op = bcdt_pkg::OP_LOAD_VARS;
         S_SP1: if (can_emit) cmd.op = bcdt_pkg::OP_LOAD_CLAUSES;
         S_VDIV, S_CDIV, S_LDIV: if (!conv_done) cmd.op = bcdt_pkg::OP_DIV_STEP;
         S_VOUT, S_COUT, S_LOUT: pop = can_emit;
         default: ;
      endcase
   end

   // Each text state emits one byte whenever the result register is free; the last byte of an item gets run_last.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hidx_ff <= '0;
         tidx_ff <= '0;
         ctot_ff <= '0;
         vtot_ff <= '0;
         cdone_ff <= '0;
         magic_ff <= 1'b0;
         end_ff <= 1'b0;
         fin_ff <= 1'b0;
         err_ff <= bcdt_pkg::ST_OK;
         ov_ff <= 1'b0;
         ol_ff <= 1'b0;
         od_ff <= 1'b0;
         os_ff <= bcdt_pkg::ST_OK;
         ob_ff <= '0;
      end else begin
         ov_ff <= ov_in;
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid && in_ready) begin
                  end_ff <= in_end;
                  if (hidx_ff != 3'd7) begin
                     hidx_ff <= hidx_ff + 3'd1;
                     unique case (hidx_ff)
                        3'd0: magic_ff <= (in_word == bcdt_pkg::CNF_MAGIC);
                        3'd1: ctot_ff[31:0] <= in_word;
                        3'd2: ctot_ff[63:32] <= in_word;
                        3'd3: vtot_ff[31:0] <= in_word;
                        3'd4: vtot_ff[63:32] <= in_word;
                        default: ;
                     endcase
                     if (!hdr_last) begin
                        if (in_end) begin
                           err_ff <= bcdt_pkg::ST_SHORT;
                           state_ff <= S_ERR;
                        end
                     end else if (!magic_ff) begin
                        err_ff <= bcdt_pkg::ST_MAGIC;
                        state_ff <= S_ERR;
                     end else if (in_end && ctot_ff != '0) begin
                        err_ff <= bcdt_pkg::ST_TRUNC;
                        state_ff <= S_ERR;
                     end else begin
                        tidx_ff <= '0;
                        state_ff <= S_PCNF;
                     end
                  end else if (in_word[31]) begin
                     state_ff <= S_LMINUS;
                  end else begin
                     state_ff <= S_LDIV;
                  end
               end
            end
            S_PCNF: if (can_emit) begin
               ob_ff <= bcdt_pkg::pcnf_char(tidx_ff);
               os_ff <= bcdt_pkg::ST_OK; ol_ff <= 1'b0; od_ff <= 1'b0;
               tidx_ff <= tidx_ff + 3'd1;
               if (tidx_ff == 3'd5) state_ff <= S_VDIV;
            end
            S_VDIV: if (conv_done) state_ff <= S_VOUT;
            S_VOUT: if (can_emit) begin
               ob_ff <= sts.digit_char;
               os_ff <= bcdt_pkg::ST_OK; ol_ff <= 1'b0; od_ff <= 1'b0;
               if (sts.digit_cnt == 5'd1) state_ff <= S_SP1;
            end
            S_SP1: if (can_emit) begin
               ob_ff <= bcdt_pkg::CH_SPACE;
               os_ff <= bcdt_pkg::ST_OK; ol_ff <= 1'b0; od_ff <= 1'b0;
               state_ff <= S_CDIV;
            end
            S_CDIV: if (conv_done) state_ff <= S_COUT;
            S_COUT: if (can_emit) begin
               ob_ff <= sts.digit_char;
               os_ff <= bcdt_pkg::ST_OK; ol_ff <= 1'b0; od_ff <= 1'b0;
               if (sts.digit_cnt == 5'd1) state_ff <= S_NL1;
            end
            S_NL1: if (can_emit) begin
               ob_ff <= bcdt_pkg::CH_NL;
               os_ff <= bcdt_pkg::ST_OK;
               tidx_ff <= '0;
               if (ctot_ff == '0 && solve_mode) begin
                  ol_ff <= 1'b0; od_ff <= 1'b0; state_ff <= S_SOLVE;
               end else if (ctot_ff == '0) begin
                  ol_ff <= 1'b1; od_ff <= 1'b1; fin_ff <= 1'b1; state_ff <= S_DEAD;
               end else begin
                  ol_ff <= 1'b1; od_ff <= 1'b0; state_ff <= S_IDLE;
               end
            end
            S_LMINUS: if (can_emit) begin
               ob_ff <= bcdt_pkg::CH_MINUS;
               os_ff <= bcdt_pkg::ST_OK; ol_ff <= 1'b0; od_ff <= 1'b0;
               state_ff <= S_LDIV;
            end
            S_LDIV: if (conv_done) state_ff <= S_LOUT;
            S_LOUT: if (can_emit) begin
               ob_ff <= sts.digit_char;
               os_ff <= bcdt_pkg::ST_OK; ol_ff <= 1'b0; od_ff <= 1'b0;
               if (sts.digit_cnt == 5'd1) state_ff <= S_LSP;
            end
            S_LSP: if (can_emit) begin
               ob_ff <= bcdt_pkg::CH_SPACE;
               os_ff <= bcdt_pkg::ST_OK; od_ff <= 1'b0;
               if (sts.lit_zero) begin
                  ol_ff <= 1'b0; state_ff <= S_LNL;
               end else if (end_ff) begin
                  ol_ff <= 1'b0; err_ff <= bcdt_pkg::ST_TRUNC; state_ff <= S_ERR;
               end else begin
                  ol_ff <= 1'b1; state_ff <= S_IDLE;
               end
            end
            S_LNL: if (can_emit) begin
               ob_ff <= bcdt_pkg::CH_NL;
               os_ff <= bcdt_pkg::ST_OK;
               cdone_ff <= cdone_inc;
               tidx_ff <= '0;
               if (cdone_inc == ctot_ff && solve_mode) begin
                  ol_ff <= 1'b0; od_ff <= 1'b0; state_ff <= S_SOLVE;
               end else if (cdone_inc == ctot_ff) begin
                  ol_ff <= 1'b1; od_ff <= 1'b1; fin_ff <= 1'b1; state_ff <= S_DEAD;
               end else if (end_ff) begin
                  ol_ff <= 1'b0; od_ff <= 1'b0;
                  err_ff <= bcdt_pkg::ST_TRUNC; state_ff <= S_ERR;
               end else begin
                  ol_ff <= 1'b1; od_ff <= 1'b0; state_ff <= S_IDLE;
               end
            end
            S_SOLVE: if (can_emit) begin
               ob_ff <= bcdt_pkg::solve_char(tidx_ff);
               os_ff <= bcdt_pkg::ST_OK;
               tidx_ff <= tidx_ff + 3'd1;
               ol_ff <= (tidx_ff == 3'd5); od_ff <= (tidx_ff == 3'd5);
               if (tidx_ff == 3'd5) begin
                  fin_ff <= 1'b1; state_ff <= S_DEAD;
               end
            end
            S_ERR: if (can_emit) begin
               ob_ff <= '0; os_ff <= err_ff;
               ol_ff <= 1'b1; od_ff <= 1'b1;
               fin_ff <= 1'b1; state_ff <= S_DEAD;
            end
            default: ;
         endcase
      end
   end

endmodule

@@ hdl/binary_cnf_to_dimacs_text_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_cnf_to_dimacs_text_core
// Converts a binary CNF image into DIMACS text, one byte per output item.
// ----------------------------------------------------------------------------
// Usage: image words enter on the req_ stream, tdata carrying the 32-bit
// word and tlast marking the final word. Text leaves on the rsp_ stream,
// one character per item, with status and job_done in tuser beside it.
// The csr_ channel sets solve mode, which adds a closing "solve" line.
// Header words are taken one per cycle. A literal is taken only while the
// block is idle; conversion runs one 16-bit limb of a divide-by-ten per
// cycle, four limbs per decimal digit, and the digits then leave as bytes.
// A negative literal adds a minus sign and a clause end adds a newline.
// The result register holds a byte until it is taken; while the receiver
// stalls the sequencer waits in its text states, though a word can still
// be accepted while it is idle. Reset clears all counts and returns to
// waiting for the magic word. Once the text is complete or an error is
// reported, input items are accepted and dropped with no output until
// the next reset.
// ----------------------------------------------------------------------------
module binary_cnf_to_dimacs_text_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,       // solve_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,      // image_word
   input  logic        req_tlast,      // image_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,      // text_byte
   output logic [2:0]  rsp_tuser,      // status [1:0], job_done [2]
   output logic        rsp_tlast       // run_last
);

   logic solve_ff;
   bcdt_pkg::dp_cmd_type cmd;
   bcdt_pkg::dp_sts_type sts;
   logic pop;
   logic [63:0] vars_val, clauses_val;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) solve_ff <= 1'b0;
      else if (csr_valid) solve_ff <= csr_data;
   end

   bcdt_ctrl u_ctrl (
      .clock, .reset, .solve_mode(solve_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_word(req_tdata), .in_end(req_tlast),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_byte(rsp_tdata), .out_status(rsp_tuser[1:0]),
      .out_last(rsp_tlast), .out_done(rsp_tuser[2]),
      .cmd, .pop, .vars_val, .clauses_val, .sts
   );

   bcdt_datapath u_dp (
      .clock, .reset, .cmd, .pop, .vars_val, .clauses_val, .sts
   );

   // An error result always closes both the run and the job.
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != bcdt_pkg::ST_OK |-> rsp_tuser[2] && rsp_tlast)
      else $error("error result without done");

   // The job-done result is also the last result of its item.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast)
      else $error("done without run_last");

   // After the job ends, no further result appears.
   a_quiet_after: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[2] |=> !rsp_tvalid)
      else $error("result after job end");

endmodule
